// ===== sv/mhpd_pkg.sv =====
// Package: widths, constants and shared types of the packet deframer.
`default_nettype none
package mhpd_pkg;

    localparam int BYTE_W    = 8;
    localparam int LOW_W     = 7;
    localparam int NUM_DATA  = 7;
    localparam int CNT_W     = 4;

    localparam logic [CNT_W-1:0] CNT_HEAD  = 4'd1;
    localparam logic [CNT_W-1:0] CNT_CHECK = 4'd9;
    localparam logic [CNT_W-1:0] CNT_DONE  = 4'd10;

    // control from the sequencer to the cell row and the output stage
    typedef struct packed {
        logic                  shift;     // push data into the cell row
        logic [BYTE_W-1:0]     data;      // restored data byte for cell 0
        logic                  done;      // checksum word taken, packet complete
        logic                  ok;        // checksum matched
        logic [LOW_W-1:0]      id;        // packet ID
        logic                  at_check;  // next body word is the checksum
    } mhpd_ctl_t;

endpackage
`default_nettype wire

// ===== sv/mhpd_if.sv =====
// Interfaces: received byte channel and completed packet channel.
`default_nettype none
interface mhpd_byte_if;
    import mhpd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mhpd_pkt_if;
    import mhpd_pkg::*;

    logic              valid;
    logic              ready;
    logic [LOW_W-1:0]  packet_id;
    logic [BYTE_W-1:0] data_0;
    logic [BYTE_W-1:0] data_1;
    logic [BYTE_W-1:0] data_2;
    logic [BYTE_W-1:0] data_3;
    logic [BYTE_W-1:0] data_4;
    logic [BYTE_W-1:0] data_5;
    logic [BYTE_W-1:0] data_6;
    logic              checksum_ok;

    modport source (output valid, output packet_id, output data_0, output data_1,
                    output data_2, output data_3, output data_4, output data_5,
                    output data_6, output checksum_ok, input ready);
    modport sink   (input valid, input packet_id, input data_0, input data_1,
                    input data_2, input data_3, input data_4, input data_5,
                    input data_6, input checksum_ok, output ready);
endinterface
`default_nettype wire

// ===== sv/msb_header_packet_deframer.sv =====
// Top level of the byte-stream packet deframer.
// Usage:
//   rx  : one received byte per word. A word with bit 7 clear opens a packet
//         (the packet ID); nine words with bit 7 set follow: head, seven data
//         words, checksum. An ID word inside a packet aborts it and is dropped.
//         Body words outside a packet are ignored.
//   pkt : one word per completed packet: ID, seven data bytes with bit 7
//         restored from the head word, and checksum_ok (7-bit sum of ID, head
//         and data against the low 7 bits of the checksum word).
//   Throughput: one rx word per cycle unless stalled; each word is handled
//   in the cycle it is accepted by the sequencer and the seven-cell data row.
//   Output: the packet word is valid on pkt in the cycle after its checksum
//   word is accepted, held in an output register.
//   Stall: while a packet word waits on pkt, rx keeps taking words; it stalls
//   only when the next word could be a checksum and the output is still full.
//   Reset: rst_n (async, active low) returns to waiting for an ID and empties
//   the output register.
`default_nettype none
module msb_header_packet_deframer (
    input  wire logic clk,
    input  wire logic rst_n,
    mhpd_byte_if.sink rx,
    mhpd_pkt_if.source pkt
);
    import mhpd_pkg::*;

    mhpd_ctl_t         ctl;
    logic              accept;
    logic [BYTE_W-1:0] chain [NUM_DATA+1];

    logic              out_valid_reg, out_valid_next;
    logic [LOW_W-1:0]  id_reg;
    logic [BYTE_W-1:0] data_reg [NUM_DATA];
    logic              ok_reg;

    assign rx.ready = !out_valid_reg || pkt.ready || !ctl.at_check;
    assign accept   = rx.valid && rx.ready;

    mhpd_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (rx.rx_byte),
        .ctl     (ctl)
    );

    assign chain[0] = ctl.data;

    // after seven shifts cell NUM_DATA-1 holds data_0
    for (genvar i = 0; i < NUM_DATA; i++)
    begin : g_cell
        mhpd_cell u_cell (
            .clk   (clk),
            .shift (ctl.shift),
            .din   (chain[i]),
            .dout  (chain[i+1])
        );
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.done)
        begin
            out_valid_next = 1'b1;
        end
        else if (pkt.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.done)
        begin
            id_reg <= ctl.id;
            ok_reg <= ctl.ok;
            for (int k = 0; k < NUM_DATA; k++)
            begin
                data_reg[k] <= chain[NUM_DATA-k];
            end
        end
    end

    assign pkt.valid       = out_valid_reg;
    assign pkt.packet_id   = id_reg;
    assign pkt.data_0      = data_reg[0];
    assign pkt.data_1      = data_reg[1];
    assign pkt.data_2      = data_reg[2];
    assign pkt.data_3      = data_reg[3];
    assign pkt.data_4      = data_reg[4];
    assign pkt.data_5      = data_reg[5];
    assign pkt.data_6      = data_reg[6];
    assign pkt.checksum_ok = ok_reg;

    // a packet must never complete while the output still holds an untaken word
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.done |-> (!out_valid_reg || pkt.ready))
        else $error("packet completed over a pending output word");

    a_done_shows: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.done |=> out_valid_reg)
        else $error("completed packet not presented");

    a_done_only_at_check: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.done |-> (ctl.at_check && accept))
        else $error("completion outside the checksum position");

    a_no_shift_at_check: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.shift |-> (!ctl.at_check && !ctl.done))
        else $error("data shift on checksum word");

endmodule
`default_nettype wire

// ===== sv/mhpd_cell.sv =====
// One cell of the data row: holds a restored byte and hands it to the next cell.
`default_nettype none
module mhpd_cell (
    input  wire logic                      clk,
    input  wire logic                      shift,
    input  wire logic [mhpd_pkg::BYTE_W-1:0] din,
    output logic      [mhpd_pkg::BYTE_W-1:0] dout
);
    import mhpd_pkg::*;

    logic [BYTE_W-1:0] byte_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            byte_reg <= din;
        end
    end

    assign dout = byte_reg;

endmodule
`default_nettype wire

// ===== sv/mhpd_ctrl.sv =====
// Packet sequencer: word count, ID, head bits and running 7-bit sum.
`default_nettype none
module mhpd_ctrl (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      accept,
    input  wire logic [mhpd_pkg::BYTE_W-1:0] rx_byte,
    output mhpd_pkg::mhpd_ctl_t            ctl
);
    import mhpd_pkg::*;

    logic              in_packet_reg, in_packet_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [LOW_W-1:0]  id_reg, id_next;
    logic [LOW_W-1:0]  head_reg, head_next;
    logic [LOW_W-1:0]  sum_reg, sum_next;
    logic [LOW_W-1:0]  sum_add;
    logic              top;

    assign top     = rx_byte[BYTE_W-1];
    assign sum_add = sum_reg + rx_byte[LOW_W-1:0];

    always_comb
    begin
        in_packet_next = in_packet_reg;
        count_next     = count_reg;
        id_next        = id_reg;
        head_next      = head_reg;
        sum_next       = sum_reg;
        ctl.shift      = 1'b0;
        ctl.done       = 1'b0;
        ctl.data       = {head_reg[0], rx_byte[LOW_W-1:0]};
        ctl.ok         = (sum_reg == rx_byte[LOW_W-1:0]);
        ctl.id         = id_reg;
        ctl.at_check   = in_packet_reg && (count_reg == CNT_CHECK);
        if (accept)
        begin
            if (!in_packet_reg)
            begin
                if (!top)
                begin
                    id_next        = rx_byte[LOW_W-1:0];
                    sum_next       = rx_byte[LOW_W-1:0];
                    count_next     = CNT_HEAD;
                    head_next      = '0;
                    in_packet_next = 1'b1;
                end
            end
            else if (!top)
            begin
                // ID word inside a packet: abort and drop it
                in_packet_next = 1'b0;
            end
            else if (count_reg == CNT_HEAD)
            begin
                head_next  = rx_byte[LOW_W-1:0];
                sum_next   = sum_add;
                count_next = count_reg + 1'b1;
            end
            else if (count_reg < CNT_CHECK)
            begin
                // head bits consumed LSB first, one per data word
                ctl.shift  = 1'b1;
                head_next  = {1'b0, head_reg[LOW_W-1:1]};
                sum_next   = sum_add;
                count_next = count_reg + 1'b1;
            end
            else
            begin
                ctl.done       = 1'b1;
                in_packet_next = 1'b0;
                count_next     = CNT_DONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_packet_reg <= 1'b0;
            count_reg     <= '0;
            id_reg        <= '0;
            head_reg      <= '0;
            sum_reg       <= '0;
        end
        else
        begin
            in_packet_reg <= in_packet_next;
            count_reg     <= count_next;
            id_reg        <= id_next;
            head_reg      <= head_next;
            sum_reg       <= sum_next;
        end
    end

endmodule
`default_nettype wire

// ===== dv/deframer_checker.sv =====
// Checker for the packet deframer: watches both channels, predicts packets and compares.
`default_nettype none
module deframer_checker (
    input  wire logic clk,
    input  wire logic rst_n,
    mhpd_byte_if      rx,
    mhpd_pkt_if       pkt,
    output int        errors,
    output int        pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import mhpd_pkg::*;

    localparam int MAX_PRINTED = 100;

    typedef struct {
        logic [LOW_W-1:0]  id;
        logic [BYTE_W-1:0] data [NUM_DATA];
        logic              ok;
    } packet_t;

    packet_t expected_pkts[$];

    // deframing state
    logic              framing;
    logic [CNT_W-1:0]  taken;
    logic [LOW_W-1:0]  cur_id;
    logic [LOW_W-1:0]  head;
    logic [LOW_W-1:0]  sum;
    logic [BYTE_W-1:0] restored [NUM_DATA];

    initial
    begin
        errors  = 0;
        pending = 0;
    end

    task automatic report(input string msg);
        // count everything, print only the first batch
        if (errors < MAX_PRINTED)
            $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic void clear_state();
        framing = 1'b0;
        taken   = '0;
        cur_id  = '0;
        head    = '0;
        sum     = '0;
        foreach (restored[i])
            restored[i] = '0;
        expected_pkts.delete();
    endfunction

    function automatic void deframe_byte(input logic [BYTE_W-1:0] b);
        packet_t p;
        int      k;
        if (!framing)
        begin
            // body words outside a packet are ignored
            if (!b[BYTE_W-1])
            begin
                framing = 1'b1;
                cur_id  = b[LOW_W-1:0];
                sum     = b[LOW_W-1:0];
                head    = '0;
                taken   = CNT_HEAD;
            end
        end
        else if (!b[BYTE_W-1])
        begin
            // ID inside a packet: abandon it, the word is dropped
            framing = 1'b0;
        end
        else if (taken == CNT_HEAD)
        begin
            head  = b[LOW_W-1:0];
            sum   = sum + b[LOW_W-1:0];
            taken = taken + 1'b1;
        end
        else if (taken < CNT_CHECK)
        begin
            k           = int'(taken) - 2;
            restored[k] = {head[k], b[LOW_W-1:0]};
            sum         = sum + b[LOW_W-1:0];
            taken       = taken + 1'b1;
        end
        else
        begin
            framing = 1'b0;
            taken   = CNT_DONE;
            p.id    = cur_id;
            foreach (restored[i])
                p.data[i] = restored[i];
            p.ok = (sum == b[LOW_W-1:0]);
            expected_pkts.push_back(p);
        end
    endfunction

    task automatic compare_packet();
        packet_t           want;
        logic [BYTE_W-1:0] got_data [NUM_DATA];
        got_data = '{pkt.data_0, pkt.data_1, pkt.data_2, pkt.data_3,
                     pkt.data_4, pkt.data_5, pkt.data_6};
        if (expected_pkts.size() == 0)
        begin
            report($sformatf("packet id %0h with nothing expected", pkt.packet_id));
            return;
        end
        want = expected_pkts.pop_front();
        if (pkt.packet_id !== want.id)
            report($sformatf("packet_id got %0h want %0h", pkt.packet_id, want.id));
        foreach (got_data[i])
            if (got_data[i] !== want.data[i])
                report($sformatf("data_%0d got %0h want %0h (id %0h)",
                                 i, got_data[i], want.data[i], want.id));
        if (pkt.checksum_ok !== want.ok)
            report($sformatf("checksum_ok got %0b want %0b (id %0h)",
                             pkt.checksum_ok, want.ok, want.id));
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            clear_state();
        else
        begin
            // output first: a packet word never comes from a word taken at the same edge
            if (pkt.valid === 1'b1 && pkt.ready === 1'b1)
                compare_packet();
            if (rx.valid === 1'b1 && rx.ready === 1'b1)
                deframe_byte(rx.rx_byte);
        end
        pending = expected_pkts.size();
    end

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
// Testbench top: clock, reset, byte stimulus, packet receiver and verdict.
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mhpd_pkg::*;

    localparam int CYCLE_LIMIT  = 200_000;
    localparam int HOLD_CYCLES  = 150;
    localparam int FRAME_WORDS  = NUM_DATA + 3;
    localparam int PHASE_WORDS  = 480;
    localparam int TAIL_CYCLES  = 10;

    logic clk = 1'b0;
    logic rst_n;

    int errors;
    int pending;
    int cycles     = 0;
    int words_sent = 0;
    int send_idle  = 23;
    int recv_idle  = 69;
    int hold_reqs  = 0;
    int holds_done = 0;

    mhpd_byte_if rx_ch ();
    mhpd_pkt_if  pkt_ch ();

    msb_header_packet_deframer u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .pkt   (pkt_ch)
    );

    deframer_checker u_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx      (rx_ch),
        .pkt     (pkt_ch),
        .errors  (errors),
        .pending (pending)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // packet receiver: random stalls, plus a long hold-off on request
    always
    begin
        @(negedge clk);
        if (hold_reqs != holds_done)
        begin
            pkt_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clk);
            holds_done = hold_reqs;
        end
        else
            pkt_ch.ready <= ($urandom_range(99) >= recv_idle);
    end

    // entered and left at a falling edge
    task automatic send_word(input logic [BYTE_W-1:0] b);
        while ($urandom_range(99) < send_idle)
        begin
            rx_ch.valid   <= 1'b0;
            rx_ch.rx_byte <= BYTE_W'($urandom);
            @(negedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        @(posedge clk);
        while (rx_ch.ready !== 1'b1)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_frame(input logic [LOW_W-1:0] id, input logic [LOW_W-1:0] fill,
                              input bit rand_body, input bit good_sum);
        logic [BYTE_W-1:0] body [NUM_DATA+1];  // head, then data
        logic [LOW_W-1:0]  sum;
        sum = id;
        foreach (body[i])
        begin
            body[i] = {1'b1, rand_body ? LOW_W'($urandom_range(127)) : fill};
            sum     = sum + body[i][LOW_W-1:0];
        end
        send_word({1'b0, id});
        foreach (body[i])
            send_word(body[i]);
        if (good_sum)
            send_word({1'b1, sum});
        else
            send_word({1'b1, sum ^ LOW_W'($urandom_range(1, 127))});
        words_sent += FRAME_WORDS;
    endtask

    // packet cut short by an ID word, which is dropped
    task automatic send_broken();
        int n;
        n = $urandom_range(0, NUM_DATA + 1);
        send_word({1'b0, LOW_W'($urandom_range(127))});
        repeat (n)
            send_word({1'b1, LOW_W'($urandom_range(127))});
        send_word({1'b0, LOW_W'($urandom_range(127))});
        words_sent += n + 2;
    endtask

    // body words between packets; ignored, so not counted
    task automatic send_stray();
        repeat ($urandom_range(1, 3))
            send_word({1'b1, LOW_W'($urandom_range(127))});
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(1, 4);
        repeat (n)
            send_word(BYTE_W'($urandom));
        words_sent += n;
    endtask

    task automatic wait_drained();
        rx_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
    endtask

    task automatic run_phase(input int s_idle, input int r_idle);
        int start;
        int pick;
        send_idle = s_idle;
        recv_idle <= r_idle;
        hold_reqs <= hold_reqs + 1;
        start = words_sent;
        while (words_sent - start < PHASE_WORDS)
        begin
            pick = $urandom_range(99);
            if (pick < 72)
                send_frame(LOW_W'($urandom_range(127)), '0, 1'b1, $urandom_range(99) < 75);
            else if (pick < 84)
                send_broken();
            else if (pick < 94)
                send_stray();
            else if (pick < 99)
                send_noise();
            else
                wait_drained();
        end
        wait_drained();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = '0;
        pkt_ch.ready  = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // all-low packet with a good checksum, a stray body word,
        // all-high packet with a bad checksum, then an aborted packet
        send_frame('0, '0, 1'b0, 1'b1);
        send_word(8'hff);
        send_frame('1, '1, 1'b0, 1'b0);
        send_word(8'h55);
        send_word(8'haa);
        send_word(8'h2a);
        wait_drained();

        run_phase(23, 69);
        run_phase(69, 23);
        run_phase(0, 0);

        repeat (TAIL_CYCLES) @(negedge clk);
        if (errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
`default_nettype wire
